// File: src/nst_pkg.sv
package nst_pkg;

	localparam int unsigned SCORE_W = 30;
	localparam int unsigned NAME_W = 64;
	localparam int unsigned PLACE_W = 4;
	localparam logic [SCORE_W-1:0] SCORE_MAX = 30'd999999999;

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_READ   = 2'd1,
		CMD_CHECK  = 2'd2,
		CMD_NOP    = 2'd3
	} cmd_t;

	typedef struct packed {
		cmd_t               cmd;
		logic [2:0]         mode;
		logic [PLACE_W-1:0] place;
		logic [SCORE_W-1:0] new_score;
		logic [NAME_W-1:0]  new_name;
	} req_t;

	typedef struct packed {
		logic               found;
		logic [SCORE_W-1:0] entry_score;
		logic [NAME_W-1:0]  entry_name;
		logic               qualifies;
		logic [PLACE_W-1:0] inserted_place;
	} rsp_t;

	typedef struct packed {
		logic               gt;
		logic [SCORE_W-1:0] score;
		logic [NAME_W-1:0]  name;
	} link_t;

endpackage

// File: src/top_n_score_table.sv
// channel | dir | handshake            | payload
// req     | in  | req_valid, req_ready | nst_pkg::req_t
// rsp     | out | rsp_valid, rsp_ready | nst_pkg::rsp_t
//
// every command is answered from the response register; a new request is taken
// each cycle while the response register is empty or being drained
// all places of a mode compare in one pass along the cell row; an insert
// shifts the lower places down one cell in the same edge
// arst_n clears all tables and the response register
// req_ready drops only while a response waits and rsp_ready is low
module top_n_score_table #(
	parameter int unsigned ENTRIES = 10,
	parameter int unsigned MODES = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  nst_pkg::req_t  req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output nst_pkg::rsp_t  rsp
);

	localparam int unsigned MODE_W = MODES > 1 ? $clog2(MODES) : 1;
	localparam int unsigned IDX_W = $clog2(ENTRIES);
	localparam logic [5:0] ENTRIES_C = 6'(ENTRIES);
	localparam logic [3:0] MODES_C = 4'(MODES);

	logic                        accept;
	logic                        mode_ok;
	logic [MODE_W-1:0]           sel;
	logic [nst_pkg::SCORE_W-1:0] score_sat;
	logic                        wr_en;
	nst_pkg::link_t              head;
	nst_pkg::link_t              link [ENTRIES];
	logic [ENTRIES-1:0]          hit;
	logic [IDX_W-1:0]            ins_idx;
	logic                        place_ok;
	logic [IDX_W-1:0]            rd_idx;
	nst_pkg::link_t              rd_link;
	nst_pkg::rsp_t               rsp_d;
	nst_pkg::rsp_t               rsp_q;
	logic                        rsp_valid_q;

	assign req_ready = ~rsp_valid_q | rsp_ready;
	assign accept = req_valid & req_ready;
	assign mode_ok = {1'b0, req.mode} < MODES_C;
	assign sel = mode_ok ? MODE_W'(req.mode) : '0;
	assign score_sat = (req.new_score > nst_pkg::SCORE_MAX) ? nst_pkg::SCORE_MAX
		: req.new_score;
	assign wr_en = accept & mode_ok & (req.cmd == nst_pkg::CMD_INSERT);

	always_comb begin
		head.gt = 1'b0;
		head.score = '0;
		head.name = '0;
	end

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		if (i == 0) begin : g_first
			nst_cell #(.MODES(MODES)) u_cell (
				.clk(clk), .arst_n(arst_n), .wr_en(wr_en), .sel(sel),
				.new_score(score_sat), .new_name(req.new_name),
				.prev(head), .next(link[i]), .hit(hit[i])
			);
		end else begin : g_rest
			nst_cell #(.MODES(MODES)) u_cell (
				.clk(clk), .arst_n(arst_n), .wr_en(wr_en), .sel(sel),
				.new_score(score_sat), .new_name(req.new_name),
				.prev(link[i-1]), .next(link[i]), .hit(hit[i])
			);
		end
	end

	always_comb begin
		ins_idx = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			ins_idx = ins_idx | (hit[i] ? IDX_W'(i) : '0);
		end
	end

	assign place_ok = {2'b00, req.place} < ENTRIES_C;
	assign rd_idx = place_ok ? IDX_W'(req.place) : '0;
	assign rd_link = link[rd_idx];

	always_comb begin
		rsp_d.found = 1'b0;
		rsp_d.entry_score = '0;
		rsp_d.entry_name = '0;
		rsp_d.qualifies = 1'b0;
		rsp_d.inserted_place = 4'(ENTRIES);
		case (req.cmd)
			nst_pkg::CMD_INSERT: begin
				if (mode_ok && (|hit)) begin
					rsp_d.inserted_place = 4'(ins_idx);
				end
			end
			nst_pkg::CMD_READ: begin
				if (mode_ok && place_ok && (rd_link.name[7:0] != 8'd0)) begin
					rsp_d.found = 1'b1;
					rsp_d.entry_score = rd_link.score;
					rsp_d.entry_name = rd_link.name;
				end
			end
			nst_pkg::CMD_CHECK: begin
				rsp_d.qualifies = mode_ok & ((link[ENTRIES-1].name[7:0] == 8'd0)
					| link[ENTRIES-1].gt);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (accept) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_q <= '0;
		end else if (accept) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	a_hit_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(hit))
		else $error("more than one insert point in the cell row");

	for (genvar i = 1; i < ENTRIES; i++) begin : g_chk
		a_sorted: assert property (@(posedge clk) disable iff (!arst_n)
			link[i-1].score >= link[i].score)
			else $error("table order broken");
	end

	a_rsp_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> rsp_valid)
		else $error("request taken without a response");

	a_found_named: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.found |-> rsp.entry_name[7:0] != 8'd0)
		else $error("found an empty entry");

endmodule

// File: src/nst_cell.sv
module nst_cell #(
	parameter int unsigned MODES = 4
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              wr_en,
	input  logic [(MODES > 1 ? $clog2(MODES) : 1)-1:0] sel,
	input  logic [nst_pkg::SCORE_W-1:0]       new_score,
	input  logic [nst_pkg::NAME_W-1:0]        new_name,
	input  nst_pkg::link_t                    prev,
	output nst_pkg::link_t                    next,
	output logic                              hit
);

	logic [nst_pkg::SCORE_W-1:0] score_q [MODES];
	logic [nst_pkg::NAME_W-1:0]  name_q  [MODES];
	logic                        gt;

	assign gt = new_score > score_q[sel];
	assign hit = gt & ~prev.gt;

	always_comb begin
		next.gt = gt;
		next.score = score_q[sel];
		next.name = name_q[sel];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int m = 0; m < MODES; m++) begin
				score_q[m] <= '0;
				name_q[m] <= '0;
			end
		end else if (wr_en && gt) begin
			if (prev.gt) begin
				score_q[sel] <= prev.score;
				name_q[sel] <= prev.name;
			end else begin
				score_q[sel] <= new_score;
				name_q[sel] <= new_name;
			end
		end
	end

endmodule
